@@ rtl/dcpid_pkg.sv @@
// ----------------------------------------------------------------------------
// dcpid_pkg: shared types and constants of the two-channel PID speed loop
// Register indexes, widths and saturation limits.
// ----------------------------------------------------------------------------
package dcpid_pkg;
    localparam int W_ERR   = 40;
    localparam int W_INT   = 48;
    localparam int W_ACC   = 64;
    localparam int W_MUL   = 64;
    localparam logic signed [W_INT-1:0] INT_LIMIT_Q = 48'sd256000;
    localparam logic signed [W_INT-1:0] INT_LOW_Q   = {1'b1, {(W_INT-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_TARGET = 3'd0, REG_INVP = 3'd1,
        REG_KP0 = 3'd2, REG_KI0 = 3'd3, REG_KD0 = 3'd4,
        REG_KP1 = 3'd5, REG_KI1 = 3'd6, REG_KD1 = 3'd7
    } reg_idx_t;

    // request to the bit-serial multiplier
    typedef struct packed {
        logic                    start;
        logic signed [W_MUL-1:0] mcand;
        logic [15:0]             mplier;
        logic                    mplier_signed;
    } mul_req_t;
endpackage

@@ rtl/dcpid_serial_mul.sv @@
// ----------------------------------------------------------------------------
// dcpid_serial_mul: shift-add multiplier, one multiplier bit per cycle
// 16-bit multiplier (signed or unsigned) times a wide signed multiplicand.
// ----------------------------------------------------------------------------
module dcpid_serial_mul
    import dcpid_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  mul_req_t                req,
    output logic                    done,
    output logic signed [W_MUL-1:0] product
);
    logic signed [W_MUL-1:0] acc_reg, mcand_reg;
    logic [15:0] mp_reg;
    logic [4:0]  cnt_reg;
    logic        sgn_reg, busy_reg, done_reg;
    logic signed [W_MUL-1:0] addend;

    // top bit of a signed multiplier has weight -2^15
    always_comb begin
        addend = '0;
        if (mp_reg[0]) addend = (sgn_reg && cnt_reg == 5'd15) ? -mcand_reg : mcand_reg;
    end

    always_ff @(posedge aclk) begin
        done_reg <= 1'b0;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg  <= 1'b1;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            mcand_reg <= req.mcand;
            mp_reg    <= req.mplier;
            sgn_reg   <= req.mplier_signed;
        end else if (busy_reg) begin
            acc_reg   <= acc_reg + addend;
            mcand_reg <= mcand_reg <<< 1;
            mp_reg    <= mp_reg >> 1;
            cnt_reg   <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd15) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end
    assign done    = done_reg;
    assign product = acc_reg;
endmodule

@@ rtl/dual_channel_pid_speed_loop.sv @@
// ----------------------------------------------------------------------------
// dual_channel_pid_speed_loop: two-channel PID motor speed controller
// Error, P, I and D terms from one shared bit-serial multiplier.
// ----------------------------------------------------------------------------
// Sequencing: five sequential products on the shared serial multiplier, then
//   the sum and output stages.
// One item in flight; s_tready stays low until the output beat is taken.
// Reset: aresetn synchronous low; registers to defaults, integral and
//   previous error of both channels to zero, output empty.
module dual_channel_pid_speed_loop
    import dcpid_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] measured_count
    input  logic        s_tuser,    // [0] channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [6:0] duty_percent, [7] zero fill
    output logic        m_tuser     // [0] drive_channel
);
    typedef enum logic [7:0] {
        ST_IDLE = 8'b00000001, ST_ERR = 8'b00000010, ST_KI = 8'b00000100,
        ST_KD = 8'b00001000, ST_DI = 8'b00010000, ST_KP = 8'b00100000,
        ST_SUM = 8'b01000000, ST_OUT = 8'b10000000
    } state_t;

    state_t state_reg;
    logic [15:0] target_reg, invp_reg;
    logic [15:0] kp_reg [2], ki_reg [2], kd_reg [2];
    logic signed [W_INT-1:0] integ_reg [2];
    logic signed [W_ERR-1:0] perr_reg [2];
    logic        ch_reg;
    logic signed [W_ERR-1:0] err_reg;
    logic signed [W_INT+1:0] i_sum_reg;
    logic signed [W_ACC-1:0] d_reg, p_reg;
    logic [6:0]  duty_reg;
    logic        m_valid_reg, m_ch_reg;
    mul_req_t    req;
    logic        mdone;
    logic signed [W_MUL-1:0] prod, prod_sh;
    logic signed [W_INT+1:0] integ_new;
    logic signed [W_ACC-1:0] total;

    dcpid_serial_mul u_mul (.aclk, .aresetn, .req, .done(mdone), .product(prod));

    assign prod_sh = prod >>> 8;  // floor to 8 fraction bits

    always_comb begin
        req = '0;
        req.start = 1'b0;
        if (state_reg == ST_IDLE && s_tvalid && s_tready) begin
            req.start  = 1'b1;
            req.mcand  = W_MUL'($signed({1'b0, target_reg}) - $signed({1'b0, s_tdata}));
            req.mplier = invp_reg;
        end else if (mdone) begin
            req.start = (state_reg != ST_KP);
            req.mplier_signed = 1'b1;
            unique case (state_reg)
                ST_ERR: begin
                    // full signed product is the error
                    req.mcand  = prod;
                    req.mplier = ki_reg[ch_reg];
                end
                ST_KI: begin
                    req.mcand  = W_MUL'(err_reg - perr_reg[ch_reg]);
                    req.mplier = kd_reg[ch_reg];
                end
                ST_KD: begin
                    req.mcand  = prod_sh;
                    req.mplier = invp_reg;
                    req.mplier_signed = 1'b0;
                end
                ST_DI: begin
                    req.mcand  = W_MUL'(err_reg);
                    req.mplier = kp_reg[ch_reg];
                end
                default: req.start = 1'b0;
            endcase
        end
    end

    assign integ_new = W_INT'(0) + (W_INT+2)'(integ_reg[ch_reg]) + (W_INT+2)'(prod_sh);
    assign total = W_ACC'(i_sum_reg) + d_reg + p_reg;
    assign s_tready = (state_reg == ST_IDLE) && !m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            target_reg <= 16'd200;
            invp_reg <= 16'd2560;
            for (int c = 0; c < 2; c++) begin
                kp_reg[c] <= '0; ki_reg[c] <= '0; kd_reg[c] <= '0;
                integ_reg[c] <= '0; perr_reg[c] <= '0;
            end
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (reg_idx_t'(cfg_index))
                    REG_TARGET: target_reg <= cfg_wdata;
                    REG_INVP:   invp_reg   <= cfg_wdata;
                    REG_KP0:    kp_reg[0]  <= cfg_wdata;
                    REG_KI0:    ki_reg[0]  <= cfg_wdata;
                    REG_KD0:    kd_reg[0]  <= cfg_wdata;
                    REG_KP1:    kp_reg[1]  <= cfg_wdata;
                    REG_KI1:    ki_reg[1]  <= cfg_wdata;
                    REG_KD1:    kd_reg[1]  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (s_tvalid && s_tready) begin
                    ch_reg <= s_tuser;
                    state_reg <= ST_ERR;
                end
                ST_ERR: if (mdone) begin
                    err_reg <= prod[W_ERR-1:0];
                    state_reg <= ST_KI;
                end
                ST_KI: if (mdone) begin
                    // cap above at the limit, saturate at the low end
                    if (integ_new > (W_INT+2)'(INT_LIMIT_Q))
                        i_sum_reg <= (W_INT+2)'(INT_LIMIT_Q);
                    else if (integ_new < (W_INT+2)'(INT_LOW_Q))
                        i_sum_reg <= (W_INT+2)'(INT_LOW_Q);
                    else i_sum_reg <= integ_new;
                    state_reg <= ST_KD;
                end
                ST_KD: if (mdone) state_reg <= ST_DI;
                ST_DI: if (mdone) begin
                    d_reg <= prod_sh;
                    state_reg <= ST_KP;
                end
                ST_KP: if (mdone) begin
                    p_reg <= prod_sh;
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    integ_reg[ch_reg] <= i_sum_reg[W_INT-1:0];
                    perr_reg[ch_reg] <= err_reg;
                    if (total > W_ACC'(25600)) duty_reg <= 7'd100;
                    else if (total < 0) duty_reg <= 7'd0;
                    else duty_reg <= total[14:8];
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    m_valid_reg <= 1'b1;
                    m_ch_reg <= ch_reg;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, duty_reg};
    assign m_tuser  = m_ch_reg;

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("accept while busy");
    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:0] <= 7'd100)) else $error("duty out of range");
    a_integ_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_KD) |-> (i_sum_reg <= (W_INT+2)'(INT_LIMIT_Q)))
        else $error("integral above cap");
`endif
endmodule
